>>> rtl/lts_pkg.sv
// lts_pkg: shared types and constants for the levelized topological sort
// no dependencies
package lts_pkg;

  localparam int unsigned VertexW = 4;
  localparam int unsigned MaxVerticesDefault = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    FUNC_ADD_VERTEX = 2'd0,
    FUNC_ADD_EDGE   = 2'd1,
    FUNC_REMOVE_EDGE = 2'd2,
    FUNC_RUN        = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [VertexW-1:0] src_vertex;
    logic [VertexW-1:0] dst_vertex;
  } in_req_t;

  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic [VertexW-1:0] level;
    logic               cycle_error;
    logic               last;
  } out_req_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               is_run;
    logic               is_vertex;
    logic               set_edge;
    logic               clr_edge;
    logic [VertexW-1:0] src;
    logic [VertexW-1:0] dst;
  } cmd_t;

endpackage

>>> rtl/lts_front.sv
// lts_front: accepts requests, drops out-of-range ones, queues commands
// depends on lts_pkg
module lts_front import lts_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_req_t in_data,
  output logic    cmd_valid,
  input  logic    cmd_take,
  output cmd_t    cmd
);

  localparam int unsigned Lim = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

  cmd_t        q_r [QueueDepth];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;
  logic        push, pop, in_range;
  cmd_t        c;

  assign in_stall = (cnt_r == 2'(QueueDepth));
  assign pop      = cmd_take && (cnt_r != 2'd0);
  assign in_range = (32'(in_data.src_vertex) < Lim) && (32'(in_data.dst_vertex) < Lim);

  always_comb begin
    c.is_run    = (in_data.func == FUNC_RUN);
    c.is_vertex = (in_data.func == FUNC_ADD_VERTEX) && (32'(in_data.src_vertex) < Lim);
    c.set_edge  = (in_data.func == FUNC_ADD_EDGE) && in_range;
    c.clr_edge  = (in_data.func == FUNC_REMOVE_EDGE) && in_range;
    c.src       = in_data.src_vertex;
    c.dst       = in_data.dst_vertex;
  end

  // items that do nothing are not queued
  assign push = in_valid && !in_stall && (c.is_run || c.is_vertex || c.set_edge || c.clr_edge);

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

endmodule

>>> rtl/lts_back.sv
// lts_back: graph storage, level peeling and result emission
// depends on lts_pkg
module lts_back import lts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_take,
  input  cmd_t     cmd,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam int unsigned NV = 16;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_LEVEL = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_ERR   = 5'b10000
  } st_t;

  st_t                st_r, st_nxt;
  logic [NV-1:0]      adj_r [NV];
  logic [NV-1:0]      present_r, remain_r, ready_r, targets;
  logic [NV-1:0]      ready_set, emit_left;
  logic [VertexW-1:0] lvl_r, vtx;
  logic               last_lvl;
  logic               ov_r, ov_nxt;
  out_req_t           od_r;
  logic               out_free;

  assign out_free = !ov_r || !out_stall;
  assign cmd_take = (st_r == ST_IDLE);

  always_comb begin
    targets = '0;
    for (int u = 0; u < NV; u++)
      if (remain_r[u]) targets |= adj_r[u];
    ready_set = remain_r & ~targets;
  end

  // lowest set bit of the current level
  always_comb begin
    vtx = '0;
    for (int u = NV-1; u >= 0; u--)
      if (ready_r[u]) vtx = VertexW'(u);
    emit_left = ready_r & ~(NV'(1) << vtx);
  end
  assign last_lvl = (remain_r == '0) && (emit_left == '0);

  // result register valid: held while stalled, set on each emitted result
  always_comb begin
    ov_nxt = ov_r && out_stall;
    if ((st_r == ST_EMIT || st_r == ST_ERR) && out_free) ov_nxt = 1'b1;
  end

  // check pass peels all levels first so a cyclic graph emits only the error
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (cmd_valid && cmd.is_run) st_nxt = ST_CHECK;
      ST_CHECK: begin
        if (remain_r == '0)       st_nxt = ST_LEVEL;
        else if (ready_set == '0) st_nxt = ST_ERR;
      end
      ST_LEVEL: begin
        if (remain_r == '0)       st_nxt = ST_IDLE;
        else if (ready_set == '0) st_nxt = ST_ERR;
        else                      st_nxt = ST_EMIT;
      end
      ST_EMIT: if (out_free && emit_left == '0) st_nxt = (remain_r == '0) ? ST_IDLE : ST_LEVEL;
      ST_ERR:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      present_r <= '0;
      remain_r  <= '0;
      ov_r      <= 1'b0;
      for (int u = 0; u < NV; u++) adj_r[u] <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      case (st_r)
        ST_IDLE: if (cmd_valid) begin
          if (cmd.is_vertex) begin
            present_r <= present_r | (NV'(1) << cmd.src);
          end else if (cmd.set_edge || cmd.clr_edge) begin
            present_r <= present_r | (NV'(1) << cmd.src) | (NV'(1) << cmd.dst);
            adj_r[cmd.src][cmd.dst] <= cmd.set_edge;
          end
          if (cmd.is_run) begin
            remain_r <= present_r;
            lvl_r    <= '0;
          end
        end
        ST_CHECK: begin
          if (remain_r == '0) remain_r <= present_r;
          else                remain_r <= remain_r & ~ready_set;
        end
        ST_LEVEL: begin
          ready_r  <= ready_set;
          remain_r <= remain_r & ~ready_set;
        end
        ST_EMIT: if (out_free) begin
          od_r    <= '{vertex: vtx, level: lvl_r, cycle_error: 1'b0, last: last_lvl};
          ready_r <= emit_left;
          if (emit_left == '0) lvl_r <= lvl_r + VertexW'(1);
        end
        ST_ERR: if (out_free) begin
          od_r <= '{vertex: '0, level: '0, cycle_error: 1'b1, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

>>> rtl/levelized_topological_sort.sv
// levelized_topological_sort: top level, front queue feeding the sort engine
// depends on lts_pkg, lts_front, lts_back
//
//  channel | ports                         | direction
//  input   | in_valid, in_stall, in_data   | request in: func, src_vertex, dst_vertex
//  result  | out_valid, out_stall, out_data| request out: vertex, level, cycle_error, last
//
// graph edits are applied by the back end while it is idle; the front takes one request
// per cycle while its two-entry queue has room
// a run first makes a check pass that peels every level, then peels the levels
// again and emits the vertices of each level in turn; a cyclic graph ends after
// the check with one error result; requests queue behind a run
// reset is synchronous, active low, clears the graph and all control
// out_stall holds the output register and freezes the walk until taken
module levelized_topological_sort import lts_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // front: range check and classification, into the queue
  lts_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  // back: adjacency matrix, level peel, result register
  lts_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data
  );

endmodule

>>> rtl/lts_checker.sv
// lts_checker: port-level assertions for levelized_topological_sort
// depends on lts_pkg; bound to the top level
module lts_checker import lts_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cycle_error |-> out_data.last)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cycle_error |-> out_data.vertex == '0 && out_data.level == '0)
    else $error("error result carries data");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs active after reset");

endmodule

bind levelized_topological_sort lts_checker u_lts_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);
